// ----- rtl/bre_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap range engine package
// Shared widths, operation codes and the command record passed from the
// front end to the execution unit.
// ----------------------------------------------------------------------------
package bre_pkg;

  localparam int IDX_W      = 12;  // bit index of a request
  localparam int RES_W      = 13;  // result index, holds end + 1
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_FIND_SET   = 2'd0,
    KIND_FIND_CLEAR = 2'd1,
    KIND_SET        = 2'd2,
    KIND_CLEAR      = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic             rev;       // last index below first index
    logic [IDX_W-1:0] first_idx;
    logic [IDX_W-1:0] last_idx;
  } cmd_t;

endpackage

// ----- rtl/bre_front.sv -----
// ----------------------------------------------------------------------------
// Bitmap range engine front end
// Registers an incoming request and flags reversed ranges.
// ----------------------------------------------------------------------------
module bre_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     enable,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  bre_pkg::kind_t           in_kind,
  input  logic [bre_pkg::IDX_W-1:0] in_first,
  input  logic [bre_pkg::IDX_W-1:0] in_last,
  output logic                     cmd_valid,
  input  logic                     cmd_ready,
  output bre_pkg::cmd_t            cmd
);

  logic          valid_r, valid_nxt;
  bre_pkg::cmd_t cmd_r;

  assign in_ready  = enable && (!valid_r || cmd_ready);
  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

  always_comb begin
    valid_nxt = valid_r;
    if (cmd_ready) valid_nxt = 1'b0;
    if (in_valid && in_ready) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r.kind      <= in_kind;
      cmd_r.rev       <= (in_last < in_first);
      cmd_r.first_idx <= in_first;
      cmd_r.last_idx  <= in_last;
    end
  end

endmodule

// ----- rtl/bre_fifo.sv -----
// ----------------------------------------------------------------------------
// Bitmap range engine command queue
// Short queue that decouples the front end from the execution unit.
// ----------------------------------------------------------------------------
module bre_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  bre_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output bre_pkg::cmd_t pop_data
);

  localparam int PTR_W = $clog2(bre_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(bre_pkg::FIFO_DEPTH + 1);

  bre_pkg::cmd_t    mem_r [bre_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(bre_pkg::FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(bre_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(bre_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ----- rtl/bre_back.sv -----
// ----------------------------------------------------------------------------
// Bitmap range engine execution unit
// Owns the bitmap memory, clears it after reset and walks it one word per
// cycle to search, set or clear a range.
// ----------------------------------------------------------------------------
module bre_back #(
  parameter int BITMAP_WORDS = 128,
  parameter int WORD_BITS    = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  output logic                      init_busy,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  bre_pkg::cmd_t             cmd,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bre_pkg::RES_W-1:0] out_index,
  output logic                      out_found
);

  localparam int WADDR_W = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int WCNT_W  = $clog2(BITMAP_WORDS + 1);
  localparam int LANE_W  = $clog2(WORD_BITS);
  localparam int BASE_W  = bre_pkg::RES_W;

  typedef enum logic [2:0] {
    ST_CLR  = 3'b001,
    ST_IDLE = 3'b010,
    ST_RUN  = 3'b100
  } state_t;

  logic [WORD_BITS-1:0] mem [BITMAP_WORDS];

  state_t               state_r, state_nxt;
  bre_pkg::cmd_t        cmd_r;
  logic [WCNT_W-1:0]    word_r, word_nxt;
  logic [BASE_W-1:0]    base_r, base_nxt;
  logic                 pend_r, pend_nxt;
  logic [BASE_W-1:0]    pend_base_r;
  logic [WADDR_W-1:0]   pend_word_r;
  logic [WORD_BITS-1:0] rdata_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [BASE_W-1:0]    out_index_r, out_index_nxt;
  logic                 out_found_r, out_found_nxt;

  logic                 is_find, want_set;
  logic [WORD_BITS-1:0] in_rng, match;
  logic [LANE_W-1:0]    hit_pos;
  logic                 hit, more, issue, finish, pop;
  logic                 wr_en;
  logic [WADDR_W-1:0]   wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [BASE_W-1:0]    last_ext, miss_index;

  assign init_busy  = (state_r == ST_CLR);
  assign out_valid  = out_valid_r;
  assign out_index  = out_index_r;
  assign out_found  = out_found_r;
  assign pop        = (state_r == ST_IDLE) && cmd_valid && !out_valid_r;
  assign cmd_ready  = pop;

  assign is_find    = (cmd_r.kind == bre_pkg::KIND_FIND_SET) ||
                      (cmd_r.kind == bre_pkg::KIND_FIND_CLEAR);
  assign want_set   = (cmd_r.kind == bre_pkg::KIND_FIND_SET);
  assign last_ext   = {1'b0, cmd_r.last_idx};
  assign miss_index = last_ext + 1'b1;

  // lane masks for the word returned by the memory
  always_comb begin
    logic [BASE_W-1:0] lane_idx;
    for (int i = 0; i < WORD_BITS; i++) begin
      lane_idx  = pend_base_r + BASE_W'(i);
      in_rng[i] = (lane_idx >= {1'b0, cmd_r.first_idx}) && (lane_idx <= last_ext);
    end
  end

  assign match = in_rng & (want_set ? rdata_r : ~rdata_r);
  assign hit   = pend_r && is_find && (match != '0);

  // lowest matching lane
  always_comb begin
    hit_pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (match[i]) hit_pos = LANE_W'(i);
    end
  end

  assign more   = (word_r != WCNT_W'(BITMAP_WORDS)) && (base_r <= last_ext);
  assign finish = (state_r == ST_RUN) && (hit || (!pend_r && !more));
  assign issue  = (state_r == ST_RUN) && more && !finish;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_word_r;
    wr_data = '0;
    if (state_r == ST_CLR) begin
      wr_en   = 1'b1;
      wr_addr = word_r[WADDR_W-1:0];
    end else if ((state_r == ST_RUN) && pend_r && !is_find) begin
      wr_en   = 1'b1;
      wr_data = (cmd_r.kind == bre_pkg::KIND_SET) ? (rdata_r | in_rng) : (rdata_r & ~in_rng);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    base_nxt      = base_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_index_nxt = out_index_r;
    out_found_nxt = out_found_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      ST_CLR: begin
        word_nxt = word_r + 1'b1;
        if (word_r == WCNT_W'(BITMAP_WORDS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (pop) begin
          word_nxt = '0;
          base_nxt = '0;
          pend_nxt = 1'b0;
          if (cmd.rev) begin
            out_valid_nxt = 1'b1;
            out_found_nxt = 1'b0;
            out_index_nxt = ((cmd.kind == bre_pkg::KIND_FIND_SET) ||
                             (cmd.kind == bre_pkg::KIND_FIND_CLEAR)) ?
                            ({1'b0, cmd.last_idx} + 1'b1) : '0;
          end else begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        pend_nxt = issue;
        if (issue) begin
          word_nxt = word_r + 1'b1;
          base_nxt = base_r + BASE_W'(WORD_BITS);
        end
        if (finish) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_found_nxt = hit;
          if (hit) out_index_nxt = pend_base_r + BASE_W'(hit_pos);
          else     out_index_nxt = is_find ? miss_index : '0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      word_r      <= '0;
      base_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_r      <= word_nxt;
      base_r      <= base_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_index_r <= out_index_nxt;
    out_found_r <= out_found_nxt;
    if (pop) cmd_r <= cmd;
    if (issue) begin
      pend_base_r <= base_r;
      pend_word_r <= word_r[WADDR_W-1:0];
    end
  end

  // bitmap memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (issue) rdata_r <= mem[word_r[WADDR_W-1:0]];
  end

`ifndef SYNTH
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !wr_en)
    else $error("bitmap written while idle");

  a_no_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> !out_valid_r)
    else $error("result pending during a walk");

  a_pend_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ST_RUN))
    else $error("read pending outside a walk");

  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |->
      ((out_index_r >= {1'b0, cmd_r.first_idx}) && (out_index_r <= last_ext)))
    else $error("found index outside the range");

  a_busy_blocks_pop: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> !cmd_ready)
    else $error("command taken during clearing pass");
`endif

endmodule

// ----- rtl/bitmap_range_engine.sv -----
// ----------------------------------------------------------------------------
// Bitmap range engine
// Find first set / first clear bit in a range, or set / clear a range, over a
// bitmap of BITMAP_WORDS words of WORD_BITS bits.
// Walk: from word 0 up to the word that holds range_end, at most BITMAP_WORDS
//   words; a find that hits stops at that word; a reversed range is answered
//   without a walk.
// Throughput: one request at a time in the execution unit, which walks the
//   bitmap from word 0 one word per cycle on its one write and one read port.
// Reset: synchronous; afterwards a clearing pass zeroes all BITMAP_WORDS words
//   of the memory, and in_tready stays low until it ends.
// ----------------------------------------------------------------------------
module bitmap_range_engine #(
  parameter int BITMAP_WORDS = 128,
  parameter int WORD_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // range_start[11:0], range_end[23:12]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // found_index[12:0], zero fill[15:13]
  output logic        out_tuser   // found[0]
);

  logic                      init_busy;
  logic                      fe_valid, fe_ready;
  bre_pkg::cmd_t             fe_cmd;
  logic                      q_valid, q_ready;
  bre_pkg::cmd_t             q_cmd;
  logic [bre_pkg::RES_W-1:0] res_index;

  bre_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .enable    (!init_busy),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (bre_pkg::kind_t'(in_tuser)),
    .in_first  (in_tdata[11:0]),
    .in_last   (in_tdata[23:12]),
    .cmd_valid (fe_valid),
    .cmd_ready (fe_ready),
    .cmd       (fe_cmd)
  );

  bre_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fe_valid),
    .push_ready (fe_ready),
    .push_data  (fe_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  bre_back #(
    .BITMAP_WORDS (BITMAP_WORDS),
    .WORD_BITS    (WORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .init_busy (init_busy),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_index (res_index),
    .out_found (out_tuser)
  );

  assign out_tdata = {3'b000, res_index};

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap range engine testbench
// Sends find-set, find-clear, set-range and clear-range requests over the
// input stream and checks every result against a bit-level copy of the
// bitmap or the expected result a directed row gives. A directed table runs
// first, followed by random requests. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NBITS      = 4096;
  localparam int N_RANDOM   = 1825;
  localparam int IDLE_LIMIT = 3000;  // cycles without any transfer
  localparam int HOLD_CYC   = 400;
  localparam int DRAIN_CYC  = 140;   // worst-case walk of 128 words plus overhead

  typedef struct packed {
    logic [12:0] idx;
    logic        hit;
  } result_t;

  typedef struct packed {
    bre_pkg::kind_t k;
    logic [11:0]    s;
    logic [11:0]    e;
    logic           typed;  // expected result given in the row
    logic [12:0]    xi;
    logic           xf;
  } req_row_t;

  localparam int N_DIR = 25;
  localparam req_row_t DIR_ROWS [N_DIR] = '{
    '{bre_pkg::KIND_FIND_SET,   12'd0,    12'd4095, 1'b1, 13'd4096, 1'b0},
    '{bre_pkg::KIND_FIND_CLEAR, 12'd0,    12'd4095, 1'b1, 13'd0,    1'b1},
    '{bre_pkg::KIND_FIND_CLEAR, 12'd4095, 12'd4095, 1'b1, 13'd4095, 1'b1},
    '{bre_pkg::KIND_FIND_SET,   12'd4095, 12'd4095, 1'b1, 13'd4096, 1'b0},
    '{bre_pkg::KIND_SET,        12'd0,    12'd0,    1'b1, 13'd0,    1'b0},
    '{bre_pkg::KIND_FIND_SET,   12'd0,    12'd4095, 1'b0, 13'd0,    1'b0},
    '{bre_pkg::KIND_SET,        12'd31,   12'd32,   1'b1, 13'd0,    1'b0},
    '{bre_pkg::KIND_FIND_SET,   12'd1,    12'd4095, 1'b0, 13'd0,    1'b0},
    '{bre_pkg::KIND_FIND_CLEAR, 12'd0,    12'd40,   1'b0, 13'd0,    1'b0},
    '{bre_pkg::KIND_SET,        12'd0,    12'd4095, 1'b1, 13'd0,    1'b0},
    '{bre_pkg::KIND_FIND_CLEAR, 12'd0,    12'd4095, 1'b0, 13'd0,    1'b0},
    '{bre_pkg::KIND_CLEAR,      12'd100,  12'd4095, 1'b1, 13'd0,    1'b0},
    '{bre_pkg::KIND_FIND_CLEAR, 12'd0,    12'd4095, 1'b0, 13'd0,    1'b0},
    '{bre_pkg::KIND_FIND_SET,   12'd100,  12'd4095, 1'b0, 13'd0,    1'b0},
    '{bre_pkg::KIND_FIND_SET,   12'd200,  12'd100,  1'b1, 13'd101,  1'b0},
    '{bre_pkg::KIND_FIND_CLEAR, 12'd4095, 12'd0,    1'b1, 13'd1,    1'b0},
    '{bre_pkg::KIND_SET,        12'd10,   12'd5,    1'b1, 13'd0,    1'b0},
    '{bre_pkg::KIND_CLEAR,      12'd4095, 12'd4094, 1'b1, 13'd0,    1'b0},
    '{bre_pkg::KIND_CLEAR,      12'd64,   12'd95,   1'b1, 13'd0,    1'b0},
    '{bre_pkg::KIND_FIND_SET,   12'd64,   12'd95,   1'b0, 13'd0,    1'b0},
    '{bre_pkg::KIND_FIND_CLEAR, 12'd63,   12'd96,   1'b0, 13'd0,    1'b0},
    '{bre_pkg::KIND_SET,        12'd4064, 12'd4095, 1'b1, 13'd0,    1'b0},
    '{bre_pkg::KIND_FIND_SET,   12'd3000, 12'd4095, 1'b0, 13'd0,    1'b0},
    '{bre_pkg::KIND_CLEAR,      12'd0,    12'd4095, 1'b1, 13'd0,    1'b0},
    '{bre_pkg::KIND_FIND_SET,   12'd0,    12'd4095, 1'b1, 13'd4096, 1'b0}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // range_start[11:0], range_end[23:12]
  logic [1:0]  in_tuser   = '0;   // kind[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // found_index[12:0], zero fill[15:13]
  logic        out_tuser;         // found[0]

  bitmap_range_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [NBITS-1:0] bitmap_mirror = '0;
  result_t          pending_results [$];
  bit               hold_req = 1'b0;
  int               err_cnt = 0;
  int               n_find_hit = 0, n_find_miss = 0, n_set = 0, n_clear = 0, n_rev = 0;
  int               idle_cyc = 0;

  // Applies one request to the mirror and returns what the block should answer.
  function automatic result_t bitmap_apply(bre_pkg::kind_t k, logic [11:0] s,
                                           logic [11:0] e);
    result_t r;
    int      b;
    logic    want;
    r.idx = '0;
    r.hit = 1'b0;
    if (k == bre_pkg::KIND_FIND_SET || k == bre_pkg::KIND_FIND_CLEAR) begin
      want  = (k == bre_pkg::KIND_FIND_SET);
      r.idx = {1'b0, e} + 13'd1;
      if (e >= s) begin
        for (b = s; b <= e && !r.hit; b++) begin
          if (bitmap_mirror[b] == want) begin
            r.idx = b[12:0];
            r.hit = 1'b1;
          end
        end
      end
    end else if (e >= s) begin
      for (b = s; b <= e; b++)
        bitmap_mirror[b] = (k == bre_pkg::KIND_SET);
    end
    return r;
  endfunction

  // Mostly back to back, sometimes a short gap, rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_req(bre_pkg::kind_t k, logic [11:0] s, logic [11:0] e, logic typed,
                          logic [12:0] xi, logic xf);
    int      gap;
    result_t r;
    gap = hold_req ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {e, s};
    in_tuser  <= k;
    do @(posedge clk); while (!in_tready);
    r = bitmap_apply(k, s, e);
    if (e < s) n_rev++;
    else if (k == bre_pkg::KIND_SET) n_set++;
    else if (k == bre_pkg::KIND_CLEAR) n_clear++;
    else if (r.hit) n_find_hit++;
    else n_find_miss++;
    if (typed) begin
      r.idx = xi;
      r.hit = xf;
    end
    pending_results.push_back(r);
  endtask

  // Result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        if (err_cnt < 10)
          $display("ERROR: result with nothing pending: idx=%0d found=%0b",
                   out_tdata[12:0], out_tuser);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[12:0] !== want.idx || out_tuser !== want.hit ||
            out_tdata[15:13] !== 3'b000) begin
          if (err_cnt < 10)
            $display("ERROR: expected idx=%0d found=%0b, got idx=%0d found=%0b fill=%0b",
                     want.idx, want.hit, out_tdata[12:0], out_tuser, out_tdata[15:13]);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cyc <= 0;
    else
      idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results pending",
               idle_cyc, pending_results.size());
      $display("FAIL bitmap_range_engine");
      $finish;
    end
  end

  // Receiver: random stalls, ready stretches, and one long hold-off on request
  initial begin
    int r;
    int stall;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        out_tready <= 1'b1;
        if (r < 10) begin
          repeat ($urandom_range(100, 300)) @(posedge clk);
        end else begin
          repeat ($urandom_range(1, 8)) @(posedge clk);
          stall = pick_gap();
          if (stall > 0) begin
            out_tready <= 1'b0;
            repeat (stall) @(posedge clk);
          end
        end
      end
    end
  end

  // Stimulus
  initial begin
    int             i;
    int             r;
    int             len;
    bre_pkg::kind_t k;
    logic [11:0]    s;
    logic [11:0]    e;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIR; i++)
      send_req(DIR_ROWS[i].k, DIR_ROWS[i].s, DIR_ROWS[i].e, DIR_ROWS[i].typed,
               DIR_ROWS[i].xi, DIR_ROWS[i].xf);

    for (i = 0; i < N_RANDOM; i++) begin
      if (i == 500)
        hold_req = 1'b1;
      if (i == 1200) begin
        // let the engine drain completely before carrying on
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        k = bre_pkg::kind_t'($urandom_range(0, 3));
        s = $urandom_range(1, 4095);
        e = $urandom_range(0, s - 1);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50)
          k = ($urandom_range(0, 1) != 0) ? bre_pkg::KIND_FIND_SET : bre_pkg::KIND_FIND_CLEAR;
        else if (r < 75) k = bre_pkg::KIND_SET;
        else             k = bre_pkg::KIND_CLEAR;
        r = $urandom_range(0, 99);
        if (r < 60)      len = $urandom_range(0, 40);
        else if (r < 85) len = $urandom_range(0, 500);
        else             len = $urandom_range(0, 4095);
        s = $urandom_range(0, 4095);
        e = (s + len > 4095) ? 12'd4095 : 12'(s + len);
      end
      send_req(k, s, e, 1'b0, 13'd0, 1'b0);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Covered %0d requests: finds %0d hit / %0d missed, %0d set ranges, %0d clears,",
             N_DIR + N_RANDOM, n_find_hit, n_find_miss, n_set, n_clear);
    $display("%0d reversed ranges, one long output hold-off, one full drain; %0d mismatches",
             n_rev, err_cnt);
    if (err_cnt == 0)
      $display("PASS bitmap_range_engine");
    else
      $display("FAIL bitmap_range_engine");
    $finish;
  end

endmodule
